### hdl/clr_pkg.sv
package clr_pkg;

	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SCREEN_W   = 13;
	localparam int PITCH_W    = 16;
	localparam int OFFSET_W   = 28;
	localparam int FIELD_W    = 16;
	localparam int COLOR_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW_PITCH       = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DRAWING_ENABLED = 2'd3;

	localparam logic [SCREEN_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [SCREEN_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [PITCH_W-1:0]  PITCH_RST  = 16'd2560;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef struct packed {
		logic last;
		logic no_line;
	} clr_flags_t;

endpackage

### hdl/clr_stepper.sv
module clr_stepper import clr_pkg::*; #(
	parameter int CB = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic                      adv,
	input  logic                      func,
	input  logic signed [FIELD_W-1:0] start_x,
	input  logic signed [FIELD_W-1:0] start_y,
	input  logic signed [FIELD_W-1:0] end_x,
	input  logic signed [FIELD_W-1:0] end_y,
	input  logic        [COLOR_W-1:0] line_color,
	output logic                      v_s1,
	output logic signed [CB-1:0]      x_s1,
	output logic signed [CB-1:0]      y_s1,
	output logic        [COLOR_W-1:0] color_s1,
	output clr_flags_t                flags_s1
);

	logic signed [CB-1:0]   cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic        [CB:0]     dx_q, dy_q;
	logic                   dir_x_q, dir_y_q;
	logic signed [CB+1:0]   err_q;
	logic        [COLOR_W-1:0] color_q;
	logic                   active_q;

	logic signed [CB-1:0]   sx, sy, ex, ey;
	logic signed [CB:0]     diff_x, diff_y;
	logic        [CB:0]     adx, ady;
	logic signed [CB+2:0]   e2;
	logic                   mv_x, mv_y;
	logic signed [CB-1:0]   nx_x, nx_y, nx_tx, nx_ty;
	logic        [CB:0]     nx_dx, nx_dy;
	logic                   nx_dirx, nx_diry;
	logic signed [CB+1:0]   nx_err;
	logic        [COLOR_W-1:0] nx_color;
	logic                   no_line, last;

	if (CB > FIELD_W) begin : g_wide
		assign sx = CB'($unsigned(start_x));
		assign sy = CB'($unsigned(start_y));
		assign ex = CB'($unsigned(end_x));
		assign ey = CB'($unsigned(end_y));
	end else begin : g_narrow
		assign sx = start_x[CB-1:0];
		assign sy = start_y[CB-1:0];
		assign ex = end_x[CB-1:0];
		assign ey = end_y[CB-1:0];
	end

	always_comb begin
		diff_x = (CB+1)'(ex) - (CB+1)'(sx);
		diff_y = (CB+1)'(ey) - (CB+1)'(sy);
		adx    = diff_x[CB] ? $unsigned(-diff_x) : $unsigned(diff_x);
		ady    = diff_y[CB] ? $unsigned(-diff_y) : $unsigned(diff_y);

		e2   = {err_q, 1'b0};
		mv_x = e2 > -$signed({2'b00, dy_q});
		mv_y = e2 < $signed({2'b00, dx_q});

		no_line  = 1'b0;
		nx_x     = cur_x_q;
		nx_y     = cur_y_q;
		nx_tx    = tgt_x_q;
		nx_ty    = tgt_y_q;
		nx_dx    = dx_q;
		nx_dy    = dy_q;
		nx_dirx  = dir_x_q;
		nx_diry  = dir_y_q;
		nx_err   = err_q;
		nx_color = color_q;

		if (func == FUNC_START) begin
			nx_x     = sx;
			nx_y     = sy;
			nx_tx    = ex;
			nx_ty    = ey;
			nx_dx    = adx;
			nx_dy    = ady;
			nx_dirx  = !(sx < ex);
			nx_diry  = !(sy < ey);
			nx_err   = $signed({1'b0, adx}) - $signed({1'b0, ady});
			nx_color = line_color;
		end else if (!active_q) begin
			no_line = 1'b1;
		end else begin
			nx_err = err_q - (mv_x ? $signed({1'b0, dy_q}) : '0)
			               + (mv_y ? $signed({1'b0, dx_q}) : '0);
			if (mv_x)
				nx_x = cur_x_q + (dir_x_q ? -CB'(1) : CB'(1));
			if (mv_y)
				nx_y = cur_y_q + (dir_y_q ? -CB'(1) : CB'(1));
		end

		last = !no_line && (nx_x == nx_tx) && (nx_y == nx_ty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			dir_x_q  <= 1'b0;
			dir_y_q  <= 1'b0;
			err_q    <= '0;
			color_q  <= '0;
			active_q <= 1'b0;
		end else if (take) begin
			cur_x_q  <= nx_x;
			cur_y_q  <= nx_y;
			tgt_x_q  <= nx_tx;
			tgt_y_q  <= nx_ty;
			dx_q     <= nx_dx;
			dy_q     <= nx_dy;
			dir_x_q  <= nx_dirx;
			dir_y_q  <= nx_diry;
			err_q    <= nx_err;
			color_q  <= nx_color;
			if (!no_line)
				active_q <= !last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1             <= nx_x;
			y_s1             <= nx_y;
			color_s1         <= nx_color;
			flags_s1.last    <= last;
			flags_s1.no_line <= no_line;
		end
	end

endmodule

### hdl/clr_emit.sv
module clr_emit import clr_pkg::*; #(
	parameter int CB = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      v_s1,
	input  logic signed [CB-1:0]      x_s1,
	input  logic signed [CB-1:0]      y_s1,
	input  logic        [COLOR_W-1:0] color_s1,
	input  clr_flags_t                flags_s1,
	input  logic        [SCREEN_W-1:0] width_q,
	input  logic        [SCREEN_W-1:0] height_q,
	input  logic        [PITCH_W-1:0]  pitch_q,
	input  logic                      drawing_en_q,
	input  logic                      out_ready,
	output logic                      adv,
	output logic                      v_s2,
	output logic        [FIELD_W-1:0] x_s2,
	output logic        [FIELD_W-1:0] y_s2,
	output logic        [OFFSET_W-1:0] offset_s2,
	output logic        [COLOR_W-1:0] color_s2,
	output logic                      wr_s2,
	output logic                      last_s2,
	output logic                      nol_s2
);

	localparam int CMPW = (CB > SCREEN_W) ? CB : SCREEN_W;

	logic [CMPW-1:0]     xu, yu;
	logic [SCREEN_W-1:0] x13, y13;
	logic                on;
	logic [OFFSET_W:0]   prod, sum;

	assign adv = !v_s2 || out_ready;

	always_comb begin
		xu   = CMPW'($unsigned(x_s1));
		yu   = CMPW'($unsigned(y_s1));
		x13  = xu[SCREEN_W-1:0];
		y13  = yu[SCREEN_W-1:0];
		on   = drawing_en_q && !flags_s1.no_line
		       && !x_s1[CB-1] && (xu < CMPW'(width_q))
		       && !y_s1[CB-1] && (yu < CMPW'(height_q));
		prod = (OFFSET_W+1)'(y13) * (OFFSET_W+1)'(pitch_q);
		sum  = prod + (OFFSET_W+1)'({x13, 2'b00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			x_s2      <= flags_s1.no_line ? '0 : FIELD_W'(x_s1);
			y_s2      <= flags_s1.no_line ? '0 : FIELD_W'(y_s1);
			color_s2  <= flags_s1.no_line ? '0 : color_s1;
			offset_s2 <= on ? sum[OFFSET_W-1:0] : '0;
			wr_s2     <= on;
			last_s2   <= flags_s1.last;
			nol_s2    <= flags_s1.no_line;
		end
	end

endmodule

### hdl/clipped_line_rasterizer.sv
// Channel  Dir  Item fields (lowest bit first)
// s_axis   in   tdata: start_x, start_y, end_x, end_y, line_color; tuser: func
// m_axis   out  tdata: pixel_x, pixel_y, byte_offset, pixel_color; tuser: write_valid,
//               no_line_active; tlast: last_pixel
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One item per clock while m_axis is ready; each result is registered in both stages.
// The Bresenham step and error update finish in the accept cycle; the second
// stage does the screen clip and the y * pitch multiply for the byte offset.
// Stalls on m_axis back up through both stages; s_tready drops only when both are full.
// arst_n clears the line state (no line active) and restores register defaults.
module clipped_line_rasterizer import clr_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [95:0]            s_tdata,  // start_x, start_y, end_x, end_y, line_color
	input  logic                   s_tuser,  // func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [95:0]            m_tdata,  // pixel_x, pixel_y, byte_offset, pixel_color, pad
	output logic [1:0]             m_tuser,  // write_valid, no_line_active
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [SCREEN_W-1:0] width_q, height_q;
	logic [PITCH_W-1:0]  pitch_q;
	logic                drawing_en_q;

	logic                     take, adv2;
	logic                     v_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	logic [COLOR_W-1:0]       color_s1;
	clr_flags_t               flags_s1;

	logic [FIELD_W-1:0]  x_s2, y_s2;
	logic [OFFSET_W-1:0] offset_s2;
	logic [COLOR_W-1:0]  color_s2;
	logic                wr_s2, last_s2, nol_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WIDTH_RST;
			height_q     <= HEIGHT_RST;
			pitch_q      <= PITCH_RST;
			drawing_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:    width_q      <= cfg_data[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT:   height_q     <= cfg_data[SCREEN_W-1:0];
				REG_ROW_PITCH:       pitch_q      <= cfg_data[PITCH_W-1:0];
				REG_DRAWING_ENABLED: drawing_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_tready = !v_s1 || adv2;
	assign take     = s_tvalid && s_tready;

	clr_stepper #(.CB(COORD_BITS)) u_stepper (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.adv        (s_tready),
		.func       (s_tuser),
		.start_x    (s_tdata[15:0]),
		.start_y    (s_tdata[31:16]),
		.end_x      (s_tdata[47:32]),
		.end_y      (s_tdata[63:48]),
		.line_color (s_tdata[95:64]),
		.v_s1       (v_s1),
		.x_s1       (x_s1),
		.y_s1       (y_s1),
		.color_s1   (color_s1),
		.flags_s1   (flags_s1)
	);

	clr_emit #(.CB(COORD_BITS)) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s1         (v_s1),
		.x_s1         (x_s1),
		.y_s1         (y_s1),
		.color_s1     (color_s1),
		.flags_s1     (flags_s1),
		.width_q      (width_q),
		.height_q     (height_q),
		.pitch_q      (pitch_q),
		.drawing_en_q (drawing_en_q),
		.out_ready    (m_tready),
		.adv          (adv2),
		.v_s2         (m_tvalid),
		.x_s2         (x_s2),
		.y_s2         (y_s2),
		.offset_s2    (offset_s2),
		.color_s2     (color_s2),
		.wr_s2        (wr_s2),
		.last_s2      (last_s2),
		.nol_s2       (nol_s2)
	);

	assign m_tdata = {4'b0000, color_s2, offset_s2, y_s2, x_s2};
	assign m_tuser = {nol_s2, wr_s2};
	assign m_tlast = last_s2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while output side can drain");

	a_no_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tlast && !m_tuser[0]))
		else $error("no-line item carries nonzero payload");

	a_write_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> drawing_en_q)
		else $error("write flagged while drawing disabled");

	a_offset_zero_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[59:32] == '0))
		else $error("byte offset nonzero on skipped point");

endmodule

### test/tb_clipped_line_rasterizer.sv
module tb_clipped_line_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;
	import clr_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_SETTING = 65;
	localparam int NUM_SETTINGS = 6;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [OFFSET_W-1:0] offset;
		logic [COLOR_W-1:0] color;
		logic wr;
		logic last;
		logic no_line;
	} pixel_t;

	class raster_tracker;
		int unsigned scr_w, scr_h, pitch;
		bit draw_en;
		longint cx, cy, tx, ty, dx, dy, err;
		bit x_down, y_down, line_on;
		logic [31:0] ink;
		pixel_t pending[$];
		int errors, checked, accepted, starts, idle_steps, writes;

		function new();
			scr_w = WIDTH_RST;
			scr_h = HEIGHT_RST;
			pitch = PITCH_RST;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SCREEN_WIDTH:    scr_w = val[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT:   scr_h = val[SCREEN_W-1:0];
				REG_ROW_PITCH:       pitch = val[PITCH_W-1:0];
				REG_DRAWING_ENABLED: draw_en = val[0];
				default: ;
			endcase
		endfunction

		// Bresenham advance plus screen clip for one accepted item
		function void accept_cmd(logic func, logic [15:0] sx, logic [15:0] sy,
				logic [15:0] ex, logic [15:0] ey, logic [31:0] col);
			pixel_t p;
			longint e2, off;
			bit on;
			p = '0;
			accepted++;
			if (func == FUNC_START) begin
				starts++;
				cx = $signed(sx);
				cy = $signed(sy);
				tx = $signed(ex);
				ty = $signed(ey);
				ink = col;
				dx = tx > cx ? tx - cx : cx - tx;
				dy = ty > cy ? ty - cy : cy - ty;
				x_down = !(cx < tx);
				y_down = !(cy < ty);
				err = dx - dy;
			end else if (!line_on) begin
				idle_steps++;
				p.no_line = 1'b1;
				pending.push_back(p);
				return;
			end else begin
				e2 = 2 * err;
				if (e2 > -dy) begin
					err -= dy;
					cx += x_down ? -1 : 1;
				end
				if (e2 < dx) begin
					err += dx;
					cy += y_down ? -1 : 1;
				end
			end
			p.last = (cx == tx && cy == ty);
			line_on = !p.last;
			on = draw_en && cx >= 0 && cx < scr_w && cy >= 0 && cy < scr_h;
			p.x = cx[15:0];
			p.y = cy[15:0];
			p.color = ink;
			p.wr = on;
			if (on) begin
				off = cy * pitch + 4 * cx;
				p.offset = off[OFFSET_W-1:0];
				writes++;
			end
			pending.push_back(p);
		endfunction

		task report(string msg);
			if (errors < 20)
				$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task diff(string name, longint unsigned got, longint unsigned want);
			if (got !== want)
				report($sformatf("result %0d field %s: got %0h want %0h",
					checked, name, got, want));
		endtask

		task match_pixel(pixel_t got);
			pixel_t want;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", checked));
				return;
			end
			want = pending.pop_front();
			diff("pixel_x", got.x, want.x);
			diff("pixel_y", got.y, want.y);
			diff("byte_offset", got.offset, want.offset);
			diff("pixel_color", got.color, want.color);
			diff("write_valid", got.wr, want.wr);
			diff("last_pixel", got.last, want.last);
			diff("no_line_active", got.no_line, want.no_line);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;  // start_x, start_y, end_x, end_y, line_color
	logic s_tuser = FUNC_START; // func
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;       // pixel_x, pixel_y, byte_offset, pixel_color, pad
	logic [1:0] m_tuser;        // write_valid, no_line_active
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	raster_tracker tracker = new();
	int tx_idle = 18;
	int rx_idle = 85;
	int quiet_cycles = 0;
	int settings_done = 0;

	clipped_line_rasterizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_pixel({m_tdata[15:0], m_tdata[31:16], m_tdata[59:32],
				m_tdata[91:60], m_tuser[0], m_tlast, m_tuser[1]});
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d items still pending", tracker.pending.size());
			$display("clipped_line_rasterizer: mismatch");
			$finish;
		end
	end

	task automatic send_item(logic func, logic [15:0] sx, logic [15:0] sy,
			logic [15:0] ex, logic [15:0] ey, logic [31:0] col);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {col, ey, ex, sy, sx};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.accept_cmd(func, sx, sy, ex, ey, col);
	endtask

	task automatic send_start(int sx, int sy, int ex, int ey, logic [31:0] col);
		send_item(FUNC_START, sx[15:0], sy[15:0], ex[15:0], ey[15:0], col);
	endtask

	// step items carry random, ignored payload
	task automatic send_step();
		logic [95:0] junk;
		junk = {$urandom, $urandom, $urandom};
		send_item(FUNC_STEP, junk[15:0], junk[31:16], junk[47:32], junk[63:48],
			junk[95:64]);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(int w, int h, int p, int en);
		logic [CFG_DATA_W-1:0] vals[4];
		logic [REG_IDX_W-1:0] idx[4];
		vals = '{w[15:0], h[15:0], p[15:0], en[15:0]};
		idx = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_ROW_PITCH, REG_DRAWING_ENABLED};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			tracker.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	function automatic int near_coord(int limit);
		case ($urandom_range(2))
			0: return int'($urandom_range(16)) - 8;
			1: return limit + int'($urandom_range(16)) - 8;
			default: return int'($urandom_range(limit));
		endcase
	endfunction

	task automatic random_lines(int count);
		int sent, sx, sy, kind, steps;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 10) begin
				send_start($urandom, $urandom, $urandom, $urandom, $urandom);
				sent++;
				steps = $urandom_range(4);
				repeat (steps) send_step();
				sent += steps;
			end else begin
				sx = near_coord(tracker.scr_w);
				sy = near_coord(tracker.scr_h);
				send_start(sx, sy, sx + int'($urandom_range(24)) - 12,
					sy + int'($urandom_range(24)) - 12, $urandom);
				sent++;
				steps = (kind < 22) ? $urandom_range(3) : 100;
				while (tracker.line_on && steps > 0) begin
					send_step();
					sent++;
					steps--;
				end
				if ($urandom_range(99) < 30) begin
					send_step();
					sent++;
				end
			end
		end
	endtask

	initial begin
		int w, h, p, en;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: drawing off, no line
		send_step();
		send_start(3, 4, 3, 4, 32'hFFFF_FFFF);
		send_step();
		send_start(0, 0, 2, 1, 32'h0);
		send_step();
		send_step();
		drain();

		program_regs(640, 480, 2560, 1);
		send_start(-1, -1, 1, 1, 32'h5A5A_0F0F);
		send_step();
		send_step();
		send_start(-32768, -32768, 32767, 32767, 32'hA5A5_A5A5);
		send_step();
		// restart mid-line, finish off the right edge
		send_start(638, 2, 640, 2, 32'h1234_5678);
		send_step();
		send_step();
		send_step();
		send_start(32767, -32768, -32768, 32767, 32'hFFFF_0000);
		send_step();
		send_start(100, 200, 97, 210, 32'h0000_FFFF);
		repeat (3) send_step();
		send_start(639, 479, 639, 477, 32'h8000_0001);
		repeat (3) send_step();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			drain();
			case (s)
				0: begin w = 640;  h = 480;  p = 2560;  en = 1; end
				1: begin w = 0;    h = 0;    p = 0;     en = 1; end
				2: begin w = 4096; h = 4096; p = 65535; en = 1; end
				3: begin w = 8191; h = 8191; p = 65535; en = 1; end
				4: begin w = 37;   h = 23;   p = $urandom_range(65535); en = 1; end
				default: begin w = 640; h = 480; p = 2560; en = 0; end
			endcase
			case (s / 2)
				0: begin tx_idle = 18; rx_idle = 85; end
				1: begin tx_idle = 85; rx_idle = 18; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			program_regs(w, h, p, en);
			random_lines(ITEMS_PER_SETTING);
		end
		drain();
		repeat (10) @(posedge clk);

		$display("ran %0d items: %0d line starts, %0d steps with no line, %0d points written",
			tracker.accepted, tracker.starts, tracker.idle_steps, tracker.writes);
		$display("%0d results checked across %0d register settings incl. empty and oversized screens",
			tracker.checked, settings_done);
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("clipped_line_rasterizer: match");
		else
			$display("clipped_line_rasterizer: mismatch");
		$finish;
	end

endmodule
